// ----- src/tof_pkg.sv -----
// Package for trajectory_outlier_filter: sizes, constants, controller/datapath command types.
// No dependencies.
package tof_pkg;
   localparam int HistDepth   = 20;
   localparam int CheckWindow = 10;
   localparam int IdxW        = $clog2(HistDepth);
   localparam int CntW        = $clog2(HistDepth + 1);
   localparam logic [20:0] SpeedSat = 21'd2097151;
   localparam logic [25:0] FloorDist = 26'd100;
   localparam logic [20:0] FloorSpeed = 21'd100;
   localparam logic [20:0] MinThreshold = 21'd300;
   localparam logic [0:0] CsrSpeedLimit = 1'b0;
   localparam logic [0:0] CsrGapLimit = 1'b1;

   typedef struct packed {
      logic load_fix;    // capture input item
      logic clear_acc;   // clear mean accumulators
      logic pair_start;  // start a speed with old=a, new=b
      logic new_is_fix;  // newer point is the incoming fix
      logic [IdxW-1:0] idx_a;
      logic [IdxW-1:0] idx_b;
      logic acc_mean;    // fold finished speed into mean stats
      logic mean_start;  // start trimmed mean division
      logic clear_win;
      logic acc_win;     // fold finished speed into window stats
   } tof_cmd_type;

   typedef struct packed {
      logic speed_done;
      logic mean_done;
      logic gap_over;    // fix vs entry idx_a
      logic reject;
   } tof_sts_type;
endpackage

// ----- src/tof_datapath.sv -----
// Datapath: history memory, pair speed unit with iterative divider, mean and window stats.
// Depends on tof_pkg.
module tof_datapath (
   input  logic clock,
   input  logic reset,
   input  tof_pkg::tof_cmd_type cmd,
   output tof_pkg::tof_sts_type sts,
   input  logic [19:0] speed_limit,
   input  logic [31:0] gap_limit_ms,
   input  logic [31:0] in_time,
   input  logic [23:0] in_x,
   input  logic [23:0] in_y,
   input  logic        wr_en,
   input  logic [tof_pkg::IdxW-1:0] wr_idx
);
   import tof_pkg::*;

   logic [79:0] hist_mem [HistDepth];
   logic [79:0] rd_a_ff, rd_b_ff;
   logic [31:0] fix_t_ff;
   logic [23:0] fix_x_ff, fix_y_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_fix) begin
         fix_t_ff <= in_time;
         fix_x_ff <= in_x;
         fix_y_ff <= in_y;
      end
      if (wr_en) hist_mem[wr_idx] <= {fix_t_ff, fix_x_ff, fix_y_ff};
      rd_a_ff <= hist_mem[cmd.idx_a];
      rd_b_ff <= hist_mem[cmd.idx_b];
   end

   // pair operands
   logic [31:0] tn, to_w;
   logic [23:0] xn, yn, xo, yo;
   always_comb begin
      {to_w, xo, yo} = rd_a_ff;
      if (cmd.new_is_fix) begin
         tn = fix_t_ff; xn = fix_x_ff; yn = fix_y_ff;
      end else begin
         {tn, xn, yn} = rd_b_ff;
      end
   end

   logic [24:0] dx, dy, adx, ady;
   logic [31:0] dt;
   assign dx  = {xn[23], xn} - {xo[23], xo};
   assign dy  = {yn[23], yn} - {yo[23], yo};
   assign adx = dx[24] ? -dx : dx;
   assign ady = dy[24] ? -dy : dy;
   assign dt  = tn - to_w;
   assign sts.gap_over = !dt[31] && (dt > gap_limit_ms);

   // speed divider: 36-bit dividend, restoring, one bit per cycle
   logic [25:0] dist_ff;
   logic [35:0] quo_ff;
   logic [31:0] rem_ff, dvs_ff;
   logic [5:0]  sbit_ff;
   logic        sbusy_ff, sdone_ff, dtpos_ff;
   logic [20:0] speed;
   logic [32:0] trial;
   assign trial = {rem_ff, quo_ff[35]} - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sbusy_ff <= 1'b0;
         sdone_ff <= 1'b0;
      end else begin
         sdone_ff <= 1'b0;
         if (cmd.pair_start) begin
            sbusy_ff <= 1'b1;
            sbit_ff  <= 6'd0;
         end else if (sbusy_ff) begin
            sbit_ff <= sbit_ff + 6'd1;
            if (sbit_ff == 6'd35) begin
               sbusy_ff <= 1'b0;
               sdone_ff <= 1'b1;
            end
         end
      end
      if (cmd.pair_start) begin
         dist_ff  <= {1'b0, adx} + {1'b0, ady};
         quo_ff   <= 36'({1'b0, adx} + {1'b0, ady}) * 36'd1000;
         rem_ff   <= '0;
         dvs_ff   <= dt;
         dtpos_ff <= !dt[31] && (dt != 32'd0);
      end else if (sbusy_ff) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[34:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], quo_ff[35]};
            quo_ff <= {quo_ff[34:0], 1'b0};
         end
      end
   end

   always_comb begin
      logic [20:0] s;
      s = '0;
      if (dtpos_ff) s = (quo_ff > 36'(SpeedSat)) ? SpeedSat : quo_ff[20:0];
      if (({1'b0, s, 1'b0} < {3'b0, speed_limit}) && (dist_ff < FloorDist)) s = FloorSpeed;
      speed = s;
   end
   assign sts.speed_done = sdone_ff;

   // mean stats
   logic [28:0] msum_ff;
   logic [20:0] mmax_ff, mmin_ff;
   logic [8:0]  mcnt_ff;
   logic        in_lim;
   assign in_lim = {1'b0, speed} <= {2'b0, speed_limit};
   always_ff @(posedge clock) begin
      if (cmd.clear_acc) begin
         msum_ff <= '0; mcnt_ff <= '0; mmax_ff <= '0; mmin_ff <= '0;
      end else if (cmd.acc_mean && in_lim) begin
         if (mcnt_ff == 9'd0 || speed > mmax_ff) mmax_ff <= speed;
         if (mcnt_ff == 9'd0 || speed < mmin_ff) mmin_ff <= speed;
         msum_ff <= msum_ff + 29'(speed);
         mcnt_ff <= mcnt_ff + 9'd1;
      end
   end

   // mean divider
   logic [28:0] mq_ff;
   logic [8:0]  mr_ff, md_ff;
   logic [4:0]  mbit_ff;
   logic        mbusy_ff, mdone_ff;
   logic [9:0]  mtrial;
   logic [20:0] mean_ff;
   assign mtrial = {mr_ff, mq_ff[28]} - {1'b0, md_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
      end else begin
         mdone_ff <= 1'b0;
         if (cmd.mean_start) begin
            mbusy_ff <= mcnt_ff > 9'd2;
            mdone_ff <= !(mcnt_ff > 9'd2);
            mbit_ff  <= '0;
         end else if (mbusy_ff) begin
            mbit_ff <= mbit_ff + 5'd1;
            if (mbit_ff == 5'd28) begin
               mbusy_ff <= 1'b0;
               mdone_ff <= 1'b1;
            end
         end
      end
      if (cmd.mean_start) begin
         mq_ff <= msum_ff - 29'(mmax_ff) - 29'(mmin_ff);
         mr_ff <= '0;
         md_ff <= mcnt_ff - 9'd2;
         mean_ff <= '0;
      end else if (mbusy_ff) begin
         if (!mtrial[9]) begin
            mr_ff <= mtrial[8:0];
            mq_ff <= {mq_ff[27:0], 1'b1};
         end else begin
            mr_ff <= {mr_ff[7:0], mq_ff[28]};
            mq_ff <= {mq_ff[27:0], 1'b0};
         end
         if (mbit_ff == 5'd28) mean_ff <= 21'({mq_ff[27:0], !mtrial[9]});
      end
   end
   assign sts.mean_done = mdone_ff;

   // window stats
   logic [25:0] wsum_ff;
   logic [4:0]  viol_ff;
   logic [22:0] mean3;
   logic        violates;
   assign mean3 = 23'(mean_ff) * 23'd3;
   assign violates = (speed > 21'(speed_limit)) ||
                     (({1'b0, speed, 1'b0} > mean3) && (speed > MinThreshold));
   always_ff @(posedge clock) begin
      if (cmd.clear_win) begin
         wsum_ff <= '0; viol_ff <= '0;
      end else if (cmd.acc_win) begin
         wsum_ff <= wsum_ff + 26'(speed);
         if (violates) viol_ff <= viol_ff + 5'd1;
      end
   end
   assign sts.reject = (viol_ff > 5'd5) ||
      ((viol_ff > 5'd2) && ({wsum_ff, 1'b0} > 27'(mean3) * 27'(CheckWindow)));
endmodule

// ----- src/tof_control.sv -----
// Controller: sequences append, gap check, pairwise mean and window check per fix.
// Depends on tof_pkg.
module tof_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_fix_valid,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_accepted,
   output logic rsp_rejected,
   output logic [4:0] rsp_history_count,
   output tof_pkg::tof_cmd_type cmd,
   input  tof_pkg::tof_sts_type sts,
   output logic wr_en,
   output logic [tof_pkg::IdxW-1:0] wr_idx
);
   import tof_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_DECIDE = 4'd1, S_GAPRD = 4'd2,
      S_GAPCHK = 4'd3, S_PRD = 4'd4, S_PSTART = 4'd5, S_PWAIT = 4'd6,
      S_MWAIT = 4'd7, S_WRD = 4'd8, S_WSTART = 4'd9, S_WWAIT = 4'd10,
      S_FINAL = 4'd11, S_OUT = 4'd12, S_MSTART = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [IdxW-1:0] base_ff, base_in;     // circular start of history
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [CntW-1:0] i_ff, i_in, j_ff, j_in;
   logic vld_ff, vld_in;
   logic acc_ff, acc_in, rej_ff, rej_in;
   logic rsp_valid_ff, rsp_valid_in;

   function automatic logic [IdxW-1:0] phys(input logic [IdxW-1:0] b,
                                             input logic [CntW-1:0] k);
      logic [CntW:0] s;
      s = (CntW+1)'(b) + (CntW+1)'(k);
      if (s >= (CntW+1)'(HistDepth)) s = s - (CntW+1)'(HistDepth);
      return IdxW'(s);
   endfunction

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_accepted = acc_ff;
   assign rsp_rejected = rej_ff;
   assign rsp_history_count = 5'(cnt_ff);

   always_comb begin
      state_in = state_ff; base_in = base_ff; cnt_in = cnt_ff;
      i_in = i_ff; j_in = j_ff; vld_in = vld_ff;
      acc_in = acc_ff; rej_in = rej_ff; rsp_valid_in = rsp_valid_ff;
      cmd = '0; wr_en = 1'b0; wr_idx = phys(base_ff, cnt_ff);
      cmd.idx_a = phys(base_ff, i_ff);
      cmd.idx_b = phys(base_ff, j_ff);
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (req_valid && !req_stall) begin
            cmd.load_fix = 1'b1;
            vld_in = req_fix_valid;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            acc_in = 1'b0; rej_in = 1'b0;
            if (!vld_ff) state_in = S_OUT;
            else if (cnt_ff < CntW'(CheckWindow)) begin
               if (cnt_ff >= CntW'(HistDepth)) begin
                  base_in = phys(base_ff, CntW'(1));
                  wr_idx = base_ff;
               end else cnt_in = cnt_ff + CntW'(1);
               wr_en = 1'b1; acc_in = 1'b1; state_in = S_OUT;
            end else begin
               if (cnt_ff >= CntW'(HistDepth)) begin
                  base_in = phys(base_ff, CntW'(1));
                  cnt_in = cnt_ff - CntW'(1);
               end
               i_in = cnt_in - CntW'(1);
               state_in = S_GAPRD;
            end
         end
         S_GAPRD: state_in = S_GAPCHK;
         S_GAPCHK: begin
            // address issued last cycle with i; read data valid now
            cmd.new_is_fix = 1'b1;
            if (sts.gap_over) begin
               cnt_in = CntW'(1);
               wr_idx = base_ff; wr_en = 1'b1;
               acc_in = 1'b1; state_in = S_OUT;
            end else begin
               cmd.clear_acc = 1'b1;
               i_in = '0; j_in = CntW'(1);
               state_in = S_PRD;
            end
         end
         S_PRD: state_in = S_PSTART;
         S_PSTART: begin
            cmd.pair_start = 1'b1;
            state_in = S_PWAIT;
         end
         S_PWAIT: if (sts.speed_done) begin
            cmd.acc_mean = 1'b1;
            if (j_ff + CntW'(1) < cnt_ff) begin
               j_in = j_ff + CntW'(1); state_in = S_PRD;
            end else if (i_ff + CntW'(2) < cnt_ff) begin
               i_in = i_ff + CntW'(1); j_in = i_ff + CntW'(2); state_in = S_PRD;
            end else begin
               state_in = S_MSTART;
            end
         end
         S_MSTART: begin
            cmd.mean_start = 1'b1; state_in = S_MWAIT;
         end
         S_MWAIT: if (sts.mean_done) begin
            cmd.clear_win = 1'b1;
            i_in = cnt_ff - CntW'(1); j_in = CntW'(1);
            state_in = S_WRD;
         end
         S_WRD: state_in = S_WSTART;
         S_WSTART: begin
            cmd.new_is_fix = 1'b1;
            cmd.pair_start = 1'b1;
            state_in = S_WWAIT;
         end
         S_WWAIT: if (sts.speed_done) begin
            cmd.acc_win = 1'b1;
            if (j_ff < CntW'(CheckWindow) && j_ff < cnt_ff) begin
               j_in = j_ff + CntW'(1); i_in = i_ff - CntW'(1); state_in = S_WRD;
            end else state_in = S_FINAL;
         end
         S_FINAL: begin
            if (sts.reject) rej_in = 1'b1;
            else begin
               wr_en = 1'b1; cnt_in = cnt_ff + CntW'(1); acc_in = 1'b1;
            end
            state_in = S_OUT;
         end
         S_OUT: if (!rsp_valid_ff) begin
            rsp_valid_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; base_ff <= '0; cnt_ff <= '0;
         rsp_valid_ff <= 1'b0; acc_ff <= 1'b0; rej_ff <= 1'b0;
         i_ff <= '0; j_ff <= '0; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; base_ff <= base_in; cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in; acc_ff <= acc_in; rej_ff <= rej_in;
         i_ff <= i_in; j_ff <= j_in; vld_ff <= vld_in;
      end
   end
endmodule

// ----- src/trajectory_outlier_filter.sv -----
// Trajectory outlier filter for timestamped 2D position fixes.
// Channels: req_ input fixes and rsp_ results, valid/stall; csr_ writes with valid/ready.
// One item at a time: req_stall is high from acceptance until the result is taken.
// Invalid fix, short history or gap over: result after the decide or gap-check state.
// Full check: a memory read, a start and a bit-serial speed division per history
// pair, for all pairs (171 at 19 entries), then the trimmed mean division, then the
// same for up to 10 window pairs of the fix against the newest entries.
// The single bit-serial speed divider is shared by all of these pairs.
// History is a 20-entry circular memory; entries beyond the count are never read.
// Reset: synchronous, clears count and controller, sets registers (speed_limit 5000,
// gap_limit_ms 300000). The memory itself is not cleared.
// A result is held in rsp_ ports while rsp_stall is high; no new fix is accepted
// until it is transferred.
// csr_ready is always high; writes are meant only while idle.
// Indexes beyond the register list are ignored.
module trajectory_outlier_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_fix_valid,
   input  logic [31:0] req_capture_time_ms,
   input  logic signed [23:0] req_pos_x,
   input  logic signed [23:0] req_pos_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic        rsp_rejected,
   output logic [4:0]  rsp_history_count,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);
   import tof_pkg::*;

   logic [19:0] speed_limit_ff;
   logic [31:0] gap_limit_ff;
   tof_cmd_type cmd;
   tof_sts_type sts;
   logic wr_en;
   logic [IdxW-1:0] wr_idx;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff <= 20'd5000;
         gap_limit_ff   <= 32'd300000;
      end else if (csr_valid) begin
         if (csr_index == CsrSpeedLimit) speed_limit_ff <= csr_data[19:0];
         if (csr_index == CsrGapLimit) gap_limit_ff <= csr_data;
      end
   end

   tof_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_fix_valid,
      .rsp_valid, .rsp_stall, .rsp_accepted, .rsp_rejected, .rsp_history_count,
      .cmd, .sts, .wr_en, .wr_idx
   );

   tof_datapath u_dp (
      .clock, .reset, .cmd, .sts,
      .speed_limit(speed_limit_ff), .gap_limit_ms(gap_limit_ff),
      .in_time(req_capture_time_ms), .in_x(req_pos_x), .in_y(req_pos_y),
      .wr_en, .wr_idx
   );
endmodule

// ----- src/tof_checker.sv -----
// Port-level checker for trajectory_outlier_filter, bound to the top level.
// Depends on nothing beyond the top level's ports.
module tof_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_accepted,
   input logic rsp_rejected,
   input logic [4:0] rsp_history_count
);
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_accepted && rsp_rejected)) else $error("acc and rej");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_history_count <= 5'd20) else $error("count range");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("second transfer");
   a_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_history_count != 5'd0) else $error("empty");
endmodule

bind trajectory_outlier_filter tof_checker u_tof_checker (.*);
